>>> rtl/core/pvec_pkg.sv
// Package for the plane vertex extent classifier: store geometry, fixed-point
// widths, codes, the state machine type and the record that moves along the cell row.
// No dependencies.
package pvec_pkg;

   localparam int VTX_DEPTH = 256;
   localparam int ADDR_W = $clog2(VTX_DEPTH);
   localparam int CNT_W = $clog2(VTX_DEPTH + 1);

   localparam int CSR_W = 9;
   localparam int INDEX_W = 8;
   localparam int CNT_CMP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int IDX_CMP_W = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   localparam int COORD_W = 24;
   localparam int NORM_W = 16;
   localparam int VTX_W = 3 * COORD_W;
   localparam int PROD_W = COORD_W + NORM_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int FRAC_SHIFT = 14;
   localparam int DIST_W = 28;
   localparam int NUM_CELLS = 3;

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_SHIFT - 1);
   localparam logic signed [DIST_W-1:0] DIST_HI = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_LO = {1'b1, {(DIST_W-1){1'b0}}};

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } pvec_state_type;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic [VTX_W-1:0]        coords;
      logic signed [SUM_W-1:0] sum;
   } pvec_lane_type;

endpackage

>>> rtl/core/pvec_cell.sv
// One multiply-accumulate cell of the dot-product row: adds its normal component times
// the lowest coordinate of the passing vertex and hands the rest to its neighbor.
// Depends on pvec_pkg.
module pvec_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [pvec_pkg::NORM_W-1:0]  coef,
   input  pvec_pkg::pvec_lane_type             lane_in,
   output pvec_pkg::pvec_lane_type             lane_out
);

   logic signed [pvec_pkg::COORD_W-1:0] coord;
   logic signed [pvec_pkg::PROD_W-1:0]  prod;
   logic signed [pvec_pkg::SUM_W-1:0]   sum_in;
   logic                                valid_ff;
   logic                                last_ff;
   logic [pvec_pkg::VTX_W-1:0]          coords_ff;
   logic signed [pvec_pkg::SUM_W-1:0]   sum_ff;

   assign coord = lane_in.coords[pvec_pkg::COORD_W-1:0];
   assign prod = coef * coord;
   assign sum_in = lane_in.sum + {prod[pvec_pkg::PROD_W-1], prod};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         valid_ff <= lane_in.valid;
         last_ff <= lane_in.valid && lane_in.last;
      end
   end

   always_ff @(posedge clock) begin
      coords_ff <= lane_in.coords >> pvec_pkg::COORD_W;
      sum_ff <= sum_in;
   end

   assign lane_out.valid = valid_ff;
   assign lane_out.last = last_ff;
   assign lane_out.coords = coords_ff;
   assign lane_out.sum = sum_ff;

endmodule

>>> rtl/core/pvec_extent.sv
// Distance and extent stage: rounds the dot product, subtracts the plane offset,
// saturates, and keeps the running minimum and maximum. Depends on pvec_pkg.
module pvec_extent (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [pvec_pkg::COORD_W-1:0]  offset,
   input  pvec_pkg::pvec_lane_type              lane_in,
   output logic signed [pvec_pkg::DIST_W-1:0]   dist_min,
   output logic signed [pvec_pkg::DIST_W-1:0]   dist_max,
   output logic                                 done
);

   localparam int Q_W = pvec_pkg::SUM_W - pvec_pkg::FRAC_SHIFT;
   localparam int WIDE_W = pvec_pkg::DIST_W + 1;

   logic signed [Q_W-1:0]                quot;
   logic signed [WIDE_W-1:0]             dist_wide;
   logic signed [pvec_pkg::DIST_W-1:0]   dist_sat;
   logic                                 dv_ff;
   logic                                 dl_ff;
   logic signed [pvec_pkg::DIST_W-1:0]   dist_ff;
   logic signed [pvec_pkg::DIST_W-1:0]   min_ff;
   logic signed [pvec_pkg::DIST_W-1:0]   max_ff;
   logic                                 done_ff;

   assign quot = lane_in.sum[pvec_pkg::SUM_W-1:pvec_pkg::FRAC_SHIFT];
   assign dist_wide = {{(WIDE_W-Q_W){quot[Q_W-1]}}, quot}
                    - {{(WIDE_W-pvec_pkg::COORD_W){offset[pvec_pkg::COORD_W-1]}}, offset};

   always_comb begin
      if (dist_wide[WIDE_W-1] != dist_wide[WIDE_W-2]) begin
         dist_sat = dist_wide[WIDE_W-1] ? pvec_pkg::DIST_LO : pvec_pkg::DIST_HI;
      end else begin
         dist_sat = dist_wide[pvec_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
         dl_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         dv_ff <= lane_in.valid;
         dl_ff <= lane_in.valid && lane_in.last;
         done_ff <= dv_ff && dl_ff;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_sat;
      if (start) begin
         min_ff <= pvec_pkg::DIST_HI;
         max_ff <= pvec_pkg::DIST_LO;
      end else if (dv_ff) begin
         if (dist_ff < min_ff) begin
            min_ff <= dist_ff;
         end
         if (dist_ff > max_ff) begin
            max_ff <= dist_ff;
         end
      end
   end

   assign dist_min = min_ff;
   assign dist_max = max_ff;
   assign done = done_ff;

endmodule

>>> rtl/core/plane_vertex_extent_classifier.sv
// Top level of the plane vertex extent classifier: vertex memory, query sequencer,
// the row of dot-product cells and the result register. Depends on pvec_pkg,
// pvec_cell and pvec_extent.
//
// A load request writes one vertex, and the block stays ready for the next request. A plane
// query reads the first vertex_count vertices from the memory, one per cycle, through a
// chain of a memory read, three multiply-accumulate cells, a distance stage and an extent
// stage, and holds the block until the sweep is done; the single memory read port sets the
// pace. A query over no vertices skips the sweep. A finished result waits in an output
// register, and the block keeps taking requests until a second result would need it.
module plane_vertex_extent_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pvec_pkg::CSR_W-1:0]           csr_vertex_count,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [pvec_pkg::INDEX_W-1:0]         req_vertex_index,
   input  logic signed [pvec_pkg::COORD_W-1:0]  req_pos_x,
   input  logic signed [pvec_pkg::COORD_W-1:0]  req_pos_y,
   input  logic signed [pvec_pkg::COORD_W-1:0]  req_pos_z,
   input  logic signed [pvec_pkg::NORM_W-1:0]   req_normal_x,
   input  logic signed [pvec_pkg::NORM_W-1:0]   req_normal_y,
   input  logic signed [pvec_pkg::NORM_W-1:0]   req_normal_z,
   input  logic signed [pvec_pkg::COORD_W-1:0]  req_plane_offset,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pvec_pkg::DIST_W-1:0]   rsp_dist_min,
   output logic signed [pvec_pkg::DIST_W-1:0]   rsp_dist_max,
   output logic                                 rsp_set_empty,
   output logic                                 rsp_all_nonnegative,
   output logic                                 rsp_all_nonpositive,
   output logic                                 rsp_plane_splits
);

   pvec_pkg::pvec_state_type              state_ff;
   pvec_pkg::pvec_state_type              state_in;
   logic [pvec_pkg::CSR_W-1:0]            csr_ff;
   logic [pvec_pkg::CNT_CMP_W-1:0]        count_wide;
   logic [pvec_pkg::CNT_W-1:0]            count_sat;
   logic [pvec_pkg::IDX_CMP_W-1:0]        index_wide;
   logic                                  index_ok;
   logic                                  req_accept;
   logic                                  query_accept;
   logic                                  load_accept;
   logic                                  issue;
   logic                                  rsp_load;
   logic [pvec_pkg::CNT_W-1:0]            n_ff;
   logic [pvec_pkg::CNT_W-1:0]            addr_ff;
   logic [pvec_pkg::CNT_W-1:0]            last_addr;
   logic signed [pvec_pkg::NORM_W-1:0]    coef_ff [pvec_pkg::NUM_CELLS];
   logic signed [pvec_pkg::COORD_W-1:0]   off_ff;
   logic [pvec_pkg::VTX_W-1:0]            mem [pvec_pkg::VTX_DEPTH];
   logic [pvec_pkg::VTX_W-1:0]            rd_data_ff;
   logic                                  rd_valid_ff;
   logic                                  rd_last_ff;
   pvec_pkg::pvec_lane_type               lane [pvec_pkg::NUM_CELLS + 1];
   logic signed [pvec_pkg::DIST_W-1:0]    ext_min;
   logic signed [pvec_pkg::DIST_W-1:0]    ext_max;
   logic                                  ext_done;
   logic                                  rsp_valid_ff;
   logic signed [pvec_pkg::DIST_W-1:0]    rsp_min_ff;
   logic signed [pvec_pkg::DIST_W-1:0]    rsp_max_ff;
   logic                                  rsp_empty_ff;
   logic                                  rsp_nonneg_ff;
   logic                                  rsp_nonpos_ff;
   logic                                  rsp_splits_ff;
   logic                                  empty;

   assign csr_ready = 1'b1;

   assign count_wide = pvec_pkg::CNT_CMP_W'(csr_ff);
   assign count_sat = (count_wide > pvec_pkg::CNT_CMP_W'(pvec_pkg::VTX_DEPTH))
                    ? pvec_pkg::CNT_W'(pvec_pkg::VTX_DEPTH)
                    : count_wide[pvec_pkg::CNT_W-1:0];
   assign index_wide = pvec_pkg::IDX_CMP_W'(req_vertex_index);
   assign index_ok = index_wide < pvec_pkg::IDX_CMP_W'(pvec_pkg::VTX_DEPTH);

   assign req_accept = req_valid && req_ready;
   assign query_accept = req_accept && (req_kind == pvec_pkg::KIND_QUERY);
   assign load_accept = req_accept && (req_kind == pvec_pkg::KIND_LOAD);
   assign last_addr = n_ff - pvec_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvec_pkg::ST_IDLE;
         csr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_vertex_count;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff <= issue;
         rd_last_ff <= issue && (addr_ff == last_addr);
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      issue = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         pvec_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_kind == pvec_pkg::KIND_QUERY)) begin
               state_in = (count_sat == '0) ? pvec_pkg::ST_FINISH : pvec_pkg::ST_RUN;
            end
         end
         pvec_pkg::ST_RUN: begin
            issue = 1'b1;
            if (addr_ff == last_addr) begin
               state_in = pvec_pkg::ST_DRAIN;
            end
         end
         pvec_pkg::ST_DRAIN: begin
            if (ext_done) begin
               state_in = pvec_pkg::ST_FINISH;
            end
         end
         pvec_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = pvec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pvec_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (query_accept) begin
         n_ff <= count_sat;
         addr_ff <= '0;
         coef_ff[0] <= req_normal_x;
         coef_ff[1] <= req_normal_y;
         coef_ff[2] <= req_normal_z;
         off_ff <= req_plane_offset;
      end else if (issue) begin
         addr_ff <= addr_ff + pvec_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_accept && index_ok) begin
         mem[req_vertex_index[pvec_pkg::ADDR_W-1:0]] <= {req_pos_z, req_pos_y, req_pos_x};
      end
      rd_data_ff <= mem[addr_ff[pvec_pkg::ADDR_W-1:0]];
   end

   assign lane[0].valid = rd_valid_ff;
   assign lane[0].last = rd_last_ff;
   assign lane[0].coords = rd_data_ff;
   assign lane[0].sum = pvec_pkg::ROUND_BIAS;

   for (genvar k = 0; k < pvec_pkg::NUM_CELLS; k++) begin : g_cell
      pvec_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coef     (coef_ff[k]),
         .lane_in  (lane[k]),
         .lane_out (lane[k+1])
      );
   end

   pvec_extent u_extent (
      .clock    (clock),
      .reset    (reset),
      .start    (query_accept),
      .offset   (off_ff),
      .lane_in  (lane[pvec_pkg::NUM_CELLS]),
      .dist_min (ext_min),
      .dist_max (ext_max),
      .done     (ext_done)
   );

   assign empty = (n_ff == '0);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_min_ff <= ext_min;
         rsp_max_ff <= ext_max;
         rsp_empty_ff <= empty;
         rsp_nonneg_ff <= !ext_min[pvec_pkg::DIST_W-1];
         rsp_nonpos_ff <= ext_max[pvec_pkg::DIST_W-1] || (ext_max == '0);
         rsp_splits_ff <= !empty && (ext_min[pvec_pkg::DIST_W-1] || (ext_min == '0))
                          && !ext_max[pvec_pkg::DIST_W-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dist_min = rsp_min_ff;
   assign rsp_dist_max = rsp_max_ff;
   assign rsp_set_empty = rsp_empty_ff;
   assign rsp_all_nonnegative = rsp_nonneg_ff;
   assign rsp_all_nonpositive = rsp_nonpos_ff;
   assign rsp_plane_splits = rsp_splits_ff;

   // The read address never runs past the vertex count during a sweep.
   a_run_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == pvec_pkg::ST_RUN |-> addr_ff < n_ff)
      else $error("read address beyond vertex count");

   // The end of a sweep reaches the extent stage only while the sequencer drains.
   a_done_drain: assert property (@(posedge clock) disable iff (reset)
      ext_done |-> state_ff == pvec_pkg::ST_DRAIN)
      else $error("sweep completion outside drain");

   // No vertex is still in flight when a new request can be taken.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == pvec_pkg::ST_IDLE |-> !rd_valid_ff && !lane[pvec_pkg::NUM_CELLS].valid)
      else $error("row not empty in idle");

   // An empty result carries both one-side flags and no split.
   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_nonneg_ff && rsp_nonpos_ff && !rsp_splits_ff)
      else $error("empty result flags inconsistent");

   // A non-empty result has an ordered interval.
   a_interval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_empty_ff |-> rsp_min_ff <= rsp_max_ff)
      else $error("minimum above maximum");

endmodule
